// ----- hdl/msrf_pkg.sv -----
package msrf_pkg;

  localparam int NumEntries = 16;
  localparam int IdxW       = 4;
  localparam int CntW       = 5;
  localparam int AddrW      = 48;
  localparam int LenW       = 13;
  localparam int ThrW       = 2;

  // operation codes
  localparam logic [3:0] MD_ALLOC     = 4'd0;
  localparam logic [3:0] MD_ALLOC_SVC = 4'd1;
  localparam logic [3:0] MD_MATCH     = 4'd2;
  localparam logic [3:0] MD_OVERLAP   = 4'd3;
  localparam logic [3:0] MD_SERVICE   = 4'd4;
  localparam logic [3:0] MD_REPEND    = 4'd5;
  localparam logic [3:0] MD_FREE      = 4'd6;
  localparam logic [3:0] MD_TO_FRONT  = 4'd7;
  localparam logic [3:0] MD_FRONT     = 4'd8;
  localparam logic [3:0] MD_SQUASH    = 4'd9;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NONE     = 2'd2;
  localparam logic [1:0] ST_NO_ALLOC = 2'd3;

  // configuration register indexes
  localparam logic REG_BLOCK_SIZE = 1'b0;
  localparam logic REG_ENTRIES    = 1'b1;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [LenW-1:0]  len;
    logic             buf_only;
    logic             copy;
    logic [AddrW-1:0] dest;
    logic [ThrW-1:0]  thread;
  } entry_t;

  // true when span [start, start+slen) and [p, p+plen) intersect
  function automatic logic span_hit(logic [AddrW-1:0] start, logic [LenW-1:0] slen,
                                    logic [AddrW-1:0] p, logic [LenW-1:0] plen);
    if (start < p) return (p - start) < AddrW'(slen);
    return (start - p) < AddrW'(plen);
  endfunction

endpackage

// ----- hdl/msrf_req_if.sv -----
interface msrf_req_if;
  import msrf_pkg::*;
  logic             valid;
  logic             ready;
  logic [3:0]       mode;
  logic [AddrW-1:0] address;
  logic [LenW-1:0]  length;
  logic             no_response;
  logic             is_copy;
  logic [AddrW-1:0] copy_dest;
  logic [IdxW-1:0]  entry_index;
  logic [ThrW-1:0]  thread_id;

  modport source (output valid, mode, address, length, no_response, is_copy, copy_dest,
                  entry_index, thread_id, input ready);
  modport sink (input valid, mode, address, length, no_response, is_copy, copy_dest,
                entry_index, thread_id, output ready);
endinterface

// ----- hdl/msrf_rsp_if.sv -----
interface msrf_rsp_if;
  import msrf_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic             found;
  logic [IdxW-1:0]  result_index;
  logic [AddrW-1:0] result_address;
  logic [CntW-1:0]  allocated_count;
  logic [CntW-1:0]  in_service_count;
  logic [CntW-1:0]  removed_count;

  modport source (output valid, status, found, result_index, result_address,
                  allocated_count, in_service_count, removed_count, input ready);
  modport sink (input valid, status, found, result_index, result_address,
                allocated_count, in_service_count, removed_count, output ready);
endinterface

// ----- hdl/miss_status_register_file.sv -----
// Miss-status holding register file.
// req_i carries one operation per transfer (allocate, match, overlap search,
// service/re-pend/free/move-to-front of an entry, pending front, thread squash).
// rsp_o returns exactly one result per operation, in order.
// cfg_we_i/cfg_idx_i/cfg_data_i write block size and usable entry count; write
// them only while no operation is in flight.
// Allocate and unknown codes go straight to the result register; entry
// operations first read their entry, then may make list passes. An allocation
// list pass reads the entry memory once per entry; a pending list pass needs no
// entry memory read. The longest operations are a free or a buffer-only service
// on a full table, which walk both lists; match and overlap searches read each
// entry visited. The single-port entry memory read sets this pace.
// One operation is worked on at a time; a new one is taken as soon as the
// previous result sits in the output register, even if rsp_o is stalled.
// A stalled rsp_o holds the result; a finished operation then waits for it.
// Reset empties the table and refills the free list; no clearing pass.
module miss_status_register_file (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [msrf_pkg::CntW-1:0] cfg_data_i,
  msrf_req_if.sink                req_i,
  msrf_rsp_if.source              rsp_o
);
  import msrf_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_ERD   = 9'b000000010,
    S_ARD   = 9'b000000100,
    S_ACK   = 9'b000001000,
    S_PPASS = 9'b000010000,
    S_SRD   = 9'b000100000,
    S_SCK   = 9'b001000000,
    S_FRONT = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [3:0]      bsz_q;
  logic [CntW-1:0] eiu_q;

  // entry payload memory
  entry_t          mem_q [NumEntries];
  entry_t          rd_data_q;
  logic [IdxW-1:0] rd_addr;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  entry_t          mem_wdata;

  // per-entry flags and lists
  logic [NumEntries-1:0] valid_q, valid_d, insvc_q, insvc_d;
  logic [IdxW-1:0] alloc_q [NumEntries];
  logic [IdxW-1:0] alloc_d [NumEntries];
  logic [IdxW-1:0] pend_q [NumEntries];
  logic [IdxW-1:0] pend_d [NumEntries];
  logic [IdxW-1:0] free_q [NumEntries];
  logic [IdxW-1:0] free_d [NumEntries];
  logic [CntW-1:0] alloc_len_q, alloc_len_d, pend_len_q, pend_len_d;
  logic [CntW-1:0] busy_q, busy_d, free_top_q, free_top_d;

  // walk state
  logic [CntW-1:0] r_q, r_d, w_q, w_d;
  logic [IdxW-1:0] cur_q, cur_d, carry_q, carry_d;

  // latched operation
  logic [3:0]       mode_q, mode_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [IdxW-1:0]  eidx_q, eidx_d;
  logic [ThrW-1:0]  thr_q, thr_d;

  // working result
  logic [1:0]       status_q, status_d;
  logic             found_q, found_d;
  logic [IdxW-1:0]  ridx_q, ridx_d;
  logic [AddrW-1:0] raddr_q, raddr_d;
  logic [CntW-1:0]  removed_q, removed_d;

  // output register
  logic             out_valid_q, out_valid_d;
  logic [1:0]       o_status_q;
  logic             o_found_q;
  logic [IdxW-1:0]  o_ridx_q;
  logic [AddrW-1:0] o_raddr_q;
  logic [CntW-1:0]  o_alloc_q, o_busy_q, o_removed_q;
  logic             o_load;

  logic accept;
  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsz_q <= 4'd6;
      eiu_q <= CntW'(NumEntries);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BLOCK_SIZE: bsz_q <= cfg_data_i[3:0];
        REG_ENTRIES:    eiu_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // entry memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    rd_data_q <= mem_q[rd_addr];
  end

  // sequencer
  always_comb begin
    logic [CntW-1:0] limit;
    logic [IdxW-1:0] n;
    logic [IdxW-1:0] e;
    logic            kill;
    logic            hit;
    logic [CntW-1:0] len;

    state_d     = state_q;
    valid_d     = valid_q;
    insvc_d     = insvc_q;
    alloc_d     = alloc_q;
    pend_d      = pend_q;
    free_d      = free_q;
    alloc_len_d = alloc_len_q;
    pend_len_d  = pend_len_q;
    busy_d      = busy_q;
    free_top_d  = free_top_q;
    r_d         = r_q;
    w_d         = w_q;
    cur_d       = cur_q;
    carry_d     = carry_q;
    mode_d      = mode_q;
    addr_d      = addr_q;
    len_d       = len_q;
    eidx_d      = eidx_q;
    thr_d       = thr_q;
    status_d    = status_q;
    found_d     = found_q;
    ridx_d      = ridx_q;
    raddr_d     = raddr_q;
    removed_d   = removed_q;
    out_valid_d = out_valid_q;
    o_load      = 1'b0;
    rd_addr     = '0;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    limit = (eiu_q < CntW'(NumEntries)) ? eiu_q : CntW'(NumEntries);
    n     = free_q[IdxW'(free_top_q - 5'd1)];
    e     = eidx_q;
    kill  = 1'b0;
    hit   = 1'b0;
    len   = (mode_q == MD_MATCH) ? alloc_len_q : pend_len_q;

    // drop the output once taken
    if (rsp_o.ready) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        // issue the entry read for entry operations and pending front
        rd_addr = (req_i.mode == MD_FRONT) ? pend_q[0] : req_i.entry_index;
        if (accept) begin
          mode_d    = req_i.mode;
          addr_d    = req_i.address;
          len_d     = req_i.length;
          eidx_d    = req_i.entry_index;
          thr_d     = req_i.thread_id;
          status_d  = ST_OK;
          found_d   = 1'b0;
          ridx_d    = '0;
          raddr_d   = '0;
          removed_d = '0;
          r_d       = '0;
          w_d       = '0;
          state_d   = S_FIN;
          case (req_i.mode)
            MD_ALLOC, MD_ALLOC_SVC: begin
              if (alloc_len_q >= limit || free_top_q == '0) begin
                status_d = ST_FULL;
              end else begin
                mem_we              = 1'b1;
                mem_waddr           = n;
                mem_wdata.addr      = req_i.address & ({AddrW{1'b1}} << bsz_q);
                mem_wdata.thread    = req_i.thread_id;
                free_top_d          = free_top_q - 5'd1;
                valid_d[n]          = 1'b1;
                alloc_d[alloc_len_q[IdxW-1:0]] = n;
                alloc_len_d         = alloc_len_q + 5'd1;
                if (req_i.mode == MD_ALLOC) begin
                  mem_wdata.len      = req_i.length;
                  mem_wdata.buf_only = req_i.no_response;
                  mem_wdata.copy     = req_i.is_copy;
                  mem_wdata.dest     = req_i.copy_dest;
                  insvc_d[n]         = 1'b0;
                  pend_d[pend_len_q[IdxW-1:0]] = n;
                  pend_len_d         = pend_len_q + 5'd1;
                end else begin
                  mem_wdata.len = (bsz_q > 4'd12) ? 13'd4096 : (13'd1 << bsz_q);
                  insvc_d[n]    = 1'b1;
                  busy_d        = busy_q + 5'd1;
                end
                ridx_d  = n;
                raddr_d = mem_wdata.addr;
              end
            end
            MD_MATCH, MD_OVERLAP: begin
              status_d = ST_NONE;
              state_d  = S_SRD;
            end
            MD_SERVICE, MD_REPEND, MD_FREE, MD_TO_FRONT: begin
              if (!valid_q[req_i.entry_index]) begin
                status_d = ST_NO_ALLOC;
              end else begin
                ridx_d  = req_i.entry_index;
                state_d = S_ERD;
              end
            end
            MD_FRONT: begin
              if (pend_len_q == '0) begin
                status_d = ST_NONE;
              end else begin
                found_d = 1'b1;
                ridx_d  = pend_q[0];
                state_d = S_ERD;
              end
            end
            MD_SQUASH: state_d = S_ARD;
            default: ;
          endcase
        end
      end

      S_ERD: begin
        raddr_d = rd_data_q.addr;
        state_d = S_FIN;
        case (mode_q)
          MD_SERVICE: begin
            if (!insvc_q[e]) begin
              if (rd_data_q.buf_only) begin
                valid_d[e]  = 1'b0;
                free_d[free_top_q[IdxW-1:0]] = e;
                free_top_d  = free_top_q + 5'd1;
                removed_d   = 5'd1;
                state_d     = S_ARD;
              end else begin
                insvc_d[e] = 1'b1;
                busy_d     = busy_q + 5'd1;
                state_d    = S_PPASS;
              end
            end
          end
          MD_REPEND: begin
            if (insvc_q[e]) begin
              insvc_d[e] = 1'b0;
              if (busy_q != '0) busy_d = busy_q - 5'd1;
              pend_d[pend_len_q[IdxW-1:0]] = e;
              pend_len_d = pend_len_q + 5'd1;
            end
          end
          MD_FREE: begin
            if (insvc_q[e] && busy_q != '0) busy_d = busy_q - 5'd1;
            insvc_d[e] = 1'b0;
            valid_d[e] = 1'b0;
            free_d[free_top_q[IdxW-1:0]] = e;
            free_top_d = free_top_q + 5'd1;
            removed_d  = 5'd1;
            state_d    = S_ARD;
          end
          MD_TO_FRONT: begin
            if (!insvc_q[e]) begin
              carry_d = e;
              state_d = S_FRONT;
            end
          end
          default: ;
        endcase
      end

      // compact the allocation list, releasing squashed entries
      S_ARD: begin
        rd_addr = alloc_q[r_q[IdxW-1:0]];
        if (r_q >= alloc_len_q) begin
          alloc_len_d = w_q;
          r_d         = '0;
          w_d         = '0;
          state_d     = S_PPASS;
        end else begin
          cur_d   = alloc_q[r_q[IdxW-1:0]];
          state_d = S_ACK;
        end
      end

      S_ACK: begin
        kill = (mode_q == MD_SQUASH) && (rd_data_q.thread == thr_q) &&
               valid_q[cur_q] && !insvc_q[cur_q];
        if (kill) begin
          valid_d[cur_q] = 1'b0;
          free_d[free_top_q[IdxW-1:0]] = cur_q;
          free_top_d = free_top_q + 5'd1;
          removed_d  = removed_q + 5'd1;
        end else if (valid_q[cur_q]) begin
          alloc_d[w_q[IdxW-1:0]] = cur_q;
          w_d = w_q + 5'd1;
        end
        r_d     = r_q + 5'd1;
        state_d = S_ARD;
      end

      // compact the pending list, keeping valid entries not in service
      S_PPASS: begin
        if (r_q >= pend_len_q) begin
          pend_len_d = w_q;
          state_d    = S_FIN;
        end else begin
          if (valid_q[pend_q[r_q[IdxW-1:0]]] && !insvc_q[pend_q[r_q[IdxW-1:0]]]) begin
            pend_d[w_q[IdxW-1:0]] = pend_q[r_q[IdxW-1:0]];
            w_d = w_q + 5'd1;
          end
          r_d = r_q + 5'd1;
        end
      end

      // search walk: read an entry, then check it
      S_SRD: begin
        rd_addr = (mode_q == MD_MATCH) ? alloc_q[r_q[IdxW-1:0]] : pend_q[r_q[IdxW-1:0]];
        if (r_q >= len) begin
          state_d = S_FIN;
        end else begin
          cur_d   = rd_addr;
          state_d = S_SCK;
        end
      end

      S_SCK: begin
        if (mode_q == MD_MATCH) begin
          hit = (rd_data_q.addr == addr_q);
        end else begin
          hit = span_hit(rd_data_q.addr, rd_data_q.len, addr_q, len_q) ||
                (rd_data_q.copy && span_hit(rd_data_q.dest, rd_data_q.len, addr_q, len_q));
        end
        if (hit) begin
          status_d = ST_OK;
          found_d  = 1'b1;
          ridx_d   = cur_q;
          raddr_d  = rd_data_q.addr;
          state_d  = S_FIN;
        end else begin
          r_d     = r_q + 5'd1;
          state_d = S_SRD;
        end
      end

      // shift the pending list down until the moved entry is reached
      S_FRONT: begin
        if (r_q >= pend_len_q) begin
          state_d = S_FIN;
        end else begin
          pend_d[r_q[IdxW-1:0]] = carry_q;
          carry_d = pend_q[r_q[IdxW-1:0]];
          r_d     = r_q + 5'd1;
          if (pend_q[r_q[IdxW-1:0]] == e) state_d = S_FIN;
        end
      end

      // hand the result to the output register when it is free
      S_FIN: begin
        if (!out_valid_q || rsp_o.ready) begin
          o_load      = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      insvc_q     <= '0;
      alloc_len_q <= '0;
      pend_len_q  <= '0;
      busy_q      <= '0;
      free_top_q  <= CntW'(NumEntries);
      for (int i = 0; i < NumEntries; i++) free_q[i] <= IdxW'(NumEntries - 1 - i);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      insvc_q     <= insvc_d;
      alloc_len_q <= alloc_len_d;
      pend_len_q  <= pend_len_d;
      busy_q      <= busy_d;
      free_top_q  <= free_top_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    alloc_q   <= alloc_d;
    pend_q    <= pend_d;
    r_q       <= r_d;
    w_q       <= w_d;
    cur_q     <= cur_d;
    carry_q   <= carry_d;
    mode_q    <= mode_d;
    addr_q    <= addr_d;
    len_q     <= len_d;
    eidx_q    <= eidx_d;
    thr_q     <= thr_d;
    status_q  <= status_d;
    found_q   <= found_d;
    ridx_q    <= ridx_d;
    raddr_q   <= raddr_d;
    removed_q <= removed_d;
    if (o_load) begin
      o_status_q  <= status_q;
      o_found_q   <= found_q;
      o_ridx_q    <= ridx_q;
      o_raddr_q   <= raddr_q;
      o_alloc_q   <= alloc_len_q;
      o_busy_q    <= busy_q;
      o_removed_q <= removed_q;
    end
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.status           = o_status_q;
  assign rsp_o.found            = o_found_q;
  assign rsp_o.result_index     = o_ridx_q;
  assign rsp_o.result_address   = o_raddr_q;
  assign rsp_o.allocated_count  = o_alloc_q;
  assign rsp_o.in_service_count = o_busy_q;
  assign rsp_o.removed_count    = o_removed_q;

  // every allocated entry is pending or in service
  a_lists_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (pend_len_q + busy_q == alloc_len_q))
    else $error("pending plus in-service count differs from allocated count");

  // allocated and free entries account for the whole table
  a_free_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (alloc_len_q + free_top_q == CntW'(NumEntries)))
    else $error("free list and allocation list out of balance");

  // in-service count matches the flag vector
  a_busy_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (CntW'($countones(insvc_q)) == busy_q))
    else $error("in-service count does not match entry flags");

  // a result is loaded only into a free or draining output register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !rsp_o.ready) |=> (out_valid_q && $stable(o_raddr_q)))
    else $error("stalled result overwritten");

endmodule

// ----- tb/tb_miss_status_register_file.sv -----
module tb_miss_status_register_file;
  import msrf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HoldOff   = 300;
  localparam int IdleLimit = 5000;
  localparam int Settle    = 60;

  typedef struct packed {
    logic [3:0]       mode;
    logic [AddrW-1:0] address;
    logic [LenW-1:0]  length;
    logic             no_resp;
    logic             is_copy;
    logic [AddrW-1:0] dest;
    logic [IdxW-1:0]  idx;
    logic [ThrW-1:0]  thr;
  } op_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             found;
    logic [IdxW-1:0]  idx;
    logic [AddrW-1:0] addr;
    logic [CntW-1:0]  alloc_cnt;
    logic [CntW-1:0]  svc_cnt;
    logic [CntW-1:0]  removed;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = REG_BLOCK_SIZE;
  logic [CntW-1:0] cfg_data_i = '0;

  msrf_req_if req_if ();
  msrf_rsp_if rsp_if ();

  miss_status_register_file DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  always #1 clk_i = ~clk_i;

  op_t  op_q[$];
  res_t result_q[$];
  int   errors = 0;
  int   n_ops = 0;
  int   n_results = 0;
  int   mode_seen[16];
  int   send_idle = 0;
  int   recv_stall = 0;
  bit   hold_req = 1'b0;

  // shadow of the table
  logic             ent_valid[NumEntries];
  logic             ent_svc[NumEntries];
  logic             ent_buf[NumEntries];
  logic             ent_copy[NumEntries];
  logic [AddrW-1:0] ent_addr[NumEntries];
  logic [AddrW-1:0] ent_dest[NumEntries];
  logic [LenW-1:0]  ent_len[NumEntries];
  logic [ThrW-1:0]  ent_thr[NumEntries];
  int free_stk[NumEntries];
  int free_n;
  int alloc_list[NumEntries];
  int alloc_n;
  int pend_list[NumEntries];
  int pend_n;
  int svc_n;
  int cfg_bs;
  int cfg_eu;

  // append one operation to the pending stimulus
  function automatic void queue_op(op_t op);
    op_q.insert(op_q.size(), op);
  endfunction

  function automatic void list_drop(bit pend, int e);
    int w;
    w = 0;
    if (pend) begin
      for (int i = 0; i < pend_n; i++)
        if (pend_list[i] != e) begin
          pend_list[w] = pend_list[i];
          w++;
        end
      pend_n = w;
    end else begin
      for (int i = 0; i < alloc_n; i++)
        if (alloc_list[i] != e) begin
          alloc_list[w] = alloc_list[i];
          w++;
        end
      alloc_n = w;
    end
  endfunction

  function automatic bit spans_meet(logic [AddrW-1:0] s, logic [LenW-1:0] slen,
                                    logic [AddrW-1:0] p, logic [LenW-1:0] plen);
    if (s < p) return (p - s) < AddrW'(slen);
    return (s - p) < AddrW'(plen);
  endfunction

  function automatic void retire_entry(int e);
    list_drop(1'b0, e);
    if (ent_svc[e]) begin
      if (svc_n > 0) svc_n--;
    end else begin
      list_drop(1'b1, e);
    end
    ent_valid[e] = 1'b0;
    ent_svc[e] = 1'b0;
    if (free_n < NumEntries) begin
      free_stk[free_n] = e;
      free_n++;
    end
  endfunction

  function automatic void table_reset();
    for (int i = 0; i < NumEntries; i++) begin
      ent_valid[i] = 1'b0;
      ent_svc[i] = 1'b0;
      free_stk[i] = NumEntries - 1 - i;
    end
    free_n = NumEntries;
    alloc_n = 0;
    pend_n = 0;
    svc_n = 0;
    cfg_bs = 6;
    cfg_eu = 16;
  endfunction

  // work out one operation's result and update the shadow table
  function automatic res_t apply_op(op_t op);
    res_t r;
    int e, n, lim;
    logic [AddrW-1:0] amask;
    bit hit;
    r = '0;
    e = op.idx;
    lim = cfg_eu < NumEntries ? cfg_eu : NumEntries;
    amask = ~((AddrW'(1) << cfg_bs) - 1);
    case (op.mode)
      MD_ALLOC, MD_ALLOC_SVC: begin
        if (alloc_n >= lim || free_n == 0) begin
          r.status = ST_FULL;
        end else begin
          free_n--;
          n = free_stk[free_n];
          ent_valid[n] = 1'b1;
          ent_addr[n] = op.address & amask;
          ent_thr[n] = op.thr;
          alloc_list[alloc_n] = n;
          alloc_n++;
          if (op.mode == MD_ALLOC) begin
            ent_len[n] = op.length;
            ent_svc[n] = 1'b0;
            ent_buf[n] = op.no_resp;
            ent_copy[n] = op.is_copy;
            ent_dest[n] = op.dest;
            pend_list[pend_n] = n;
            pend_n++;
          end else begin
            ent_len[n] = cfg_bs > 12 ? LenW'(4096) : LenW'(1 << cfg_bs);
            ent_svc[n] = 1'b1;
            ent_buf[n] = 1'b0;
            ent_copy[n] = 1'b0;
            ent_dest[n] = '0;
            svc_n++;
          end
          r.idx = IdxW'(n);
          r.addr = ent_addr[n];
        end
      end
      MD_MATCH: begin
        r.status = ST_NONE;
        for (int i = 0; i < alloc_n; i++) begin
          n = alloc_list[i];
          if (ent_addr[n] == op.address) begin
            r.status = ST_OK;
            r.found = 1'b1;
            r.idx = IdxW'(n);
            r.addr = ent_addr[n];
            break;
          end
        end
      end
      MD_OVERLAP: begin
        r.status = ST_NONE;
        for (int i = 0; i < pend_n; i++) begin
          n = pend_list[i];
          hit = spans_meet(ent_addr[n], ent_len[n], op.address, op.length);
          if (!hit && ent_copy[n])
            hit = spans_meet(ent_dest[n], ent_len[n], op.address, op.length);
          if (hit) begin
            r.status = ST_OK;
            r.found = 1'b1;
            r.idx = IdxW'(n);
            r.addr = ent_addr[n];
            break;
          end
        end
      end
      MD_SERVICE, MD_REPEND, MD_FREE, MD_TO_FRONT: begin
        if (!ent_valid[e]) begin
          r.status = ST_NO_ALLOC;
        end else begin
          r.idx = IdxW'(e);
          r.addr = ent_addr[e];
          if (op.mode == MD_SERVICE) begin
            if (!ent_svc[e]) begin
              if (ent_buf[e]) begin
                retire_entry(e);
                r.removed = CntW'(1);
              end else begin
                ent_svc[e] = 1'b1;
                list_drop(1'b1, e);
                svc_n++;
              end
            end
          end else if (op.mode == MD_REPEND) begin
            if (ent_svc[e]) begin
              ent_svc[e] = 1'b0;
              if (svc_n > 0) svc_n--;
              pend_list[pend_n] = e;
              pend_n++;
            end
          end else if (op.mode == MD_FREE) begin
            retire_entry(e);
            r.removed = CntW'(1);
          end else if (!ent_svc[e]) begin
            list_drop(1'b1, e);
            for (int i = pend_n; i > 0; i--) pend_list[i] = pend_list[i-1];
            pend_list[0] = e;
            pend_n++;
          end
        end
      end
      MD_FRONT: begin
        if (pend_n == 0) begin
          r.status = ST_NONE;
        end else begin
          r.found = 1'b1;
          r.idx = IdxW'(pend_list[0]);
          r.addr = ent_addr[pend_list[0]];
        end
      end
      MD_SQUASH: begin
        n = 0;
        while (n < alloc_n) begin
          e = alloc_list[n];
          if (ent_thr[e] == op.thr && !ent_svc[e]) begin
            retire_entry(e);
            r.removed++;
          end else begin
            n++;
          end
        end
      end
      default: ;
    endcase
    r.alloc_cnt = CntW'(alloc_n);
    r.svc_cnt = CntW'(svc_n);
    return r;
  endfunction

  function automatic logic [AddrW-1:0] any_addr();
    return AddrW'({$urandom, $urandom});
  endfunction

  // addresses clustered in a few pages so that matches and overlaps happen
  function automatic logic [AddrW-1:0] near_addr();
    if ($urandom_range(0, 9) == 0) return any_addr();
    return (AddrW'($urandom_range(0, 7)) << 12) + AddrW'($urandom_range(0, 8191));
  endfunction

  function automatic op_t rand_op();
    op_t op;
    int w;
    w = $urandom_range(0, 99);
    op.mode = w < 25 ? MD_ALLOC : w < 33 ? MD_ALLOC_SVC : w < 45 ? MD_MATCH :
              w < 57 ? MD_OVERLAP : w < 67 ? MD_SERVICE : w < 73 ? MD_REPEND :
              w < 83 ? MD_FREE : w < 89 ? MD_TO_FRONT : w < 94 ? MD_FRONT :
              w < 98 ? MD_SQUASH : 4'($urandom_range(10, 15));
    op.address = near_addr();
    if (op.mode == MD_MATCH && $urandom_range(0, 3) != 0)
      op.address = op.address & ~((AddrW'(1) << cfg_bs) - 1);
    op.length = $urandom_range(0, 9) == 0 ? LenW'($urandom) : LenW'($urandom_range(1, 256));
    op.no_resp = $urandom_range(0, 4) == 0;
    op.is_copy = $urandom_range(0, 2) == 0;
    op.dest = near_addr();
    op.idx = $urandom_range(0, 3) != 0 ? IdxW'($urandom_range(0, cfg_eu - 1))
                                       : IdxW'($urandom);
    op.thr = ThrW'($urandom);
    return op;
  endfunction

  function automatic op_t mk_op(logic [3:0] md, logic [AddrW-1:0] a, logic [LenW-1:0] len,
                                logic nr, logic cp, logic [AddrW-1:0] d,
                                logic [IdxW-1:0] ix, logic [ThrW-1:0] th);
    op_t op;
    op = '{md, a, len, nr, cp, d, ix, th};
    return op;
  endfunction

  // drive requests; predict each one as it transfers
  always @(posedge clk_i or negedge rst_ni) begin
    op_t nxt;
    res_t pred;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.mode <= '0;
      req_if.address <= '0;
      req_if.length <= '0;
      req_if.no_response <= 1'b0;
      req_if.is_copy <= 1'b0;
      req_if.copy_dest <= '0;
      req_if.entry_index <= '0;
      req_if.thread_id <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        pred = apply_op('{req_if.mode, req_if.address, req_if.length,
                          req_if.no_response, req_if.is_copy, req_if.copy_dest,
                          req_if.entry_index, req_if.thread_id});
        result_q.insert(result_q.size(), pred);
        mode_seen[req_if.mode]++;
        n_ops++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (op_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          nxt = op_q[0];
          op_q.delete(0);
          req_if.valid <= 1'b1;
          req_if.mode <= nxt.mode;
          req_if.address <= nxt.address;
          req_if.length <= nxt.length;
          req_if.no_response <= nxt.no_resp;
          req_if.is_copy <= nxt.is_copy;
          req_if.copy_dest <= nxt.dest;
          req_if.entry_index <= nxt.idx;
          req_if.thread_id <= nxt.thr;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // accept and check results; hold off for a long stretch when asked
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    res_t got, want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        got = '{rsp_if.status, rsp_if.found, rsp_if.result_index, rsp_if.result_address,
                rsp_if.allocated_count, rsp_if.in_service_count, rsp_if.removed_count};
        n_results++;
        if (result_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %p", got);
        end else begin
          want = result_q[0];
          result_q.delete(0);
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch on result %0d: expected %p, got %p", n_results, want, got);
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= HoldOff;
        rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= $urandom_range(0, 99) >= recv_stall;
      end
    end
  end

  // end the run when nothing moves for too long
  int quiet = 0;
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= IdleLimit) begin
      $display("timeout: nothing transferred for %0d cycles", IdleLimit);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic drain();
    do @(negedge clk_i);
    while (op_q.size() > 0 || result_q.size() > 0 || req_if.valid);
    repeat (Settle) @(negedge clk_i);
  endtask

  task automatic write_cfg(int bs, int eu);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_BLOCK_SIZE;
    cfg_data_i <= CntW'(bs);
    @(posedge clk_i);
    cfg_idx_i <= REG_ENTRIES;
    cfg_data_i <= CntW'(eu);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_bs = bs;
    cfg_eu = eu;
    @(negedge clk_i);
  endtask

  int phase_bs[7] = '{6, 3, 12, 3, 12, 6, 8};
  int phase_eu[7] = '{2, 16, 1, 4, 16, 8, 16};
  int stall_mode;

  initial begin
    table_reset();
    foreach (mode_seen[i]) mode_seen[i] = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int ph = 0; ph < 7; ph++) begin
      write_cfg(phase_bs[ph], phase_eu[ph]);
      stall_mode = ph % 4;
      send_idle = (stall_mode == 1) ? 47 : (stall_mode == 3) ? 38 : 0;
      recv_stall = (stall_mode == 2) ? 47 : (stall_mode == 3) ? 38 : 0;
      if (ph == 0) begin
        // corners on a two-entry table
        queue_op(mk_op(MD_FRONT, '0, 13'd1, 0, 0, '0, 4'd0, 2'd0));
        queue_op(mk_op(MD_MATCH, '0, 13'd1, 0, 0, '0, 4'd0, 2'd0));
        queue_op(mk_op(MD_SERVICE, '0, 13'd1, 0, 0, '0, 4'd5, 2'd0));
        queue_op(mk_op(MD_ALLOC, '1, 13'd4096, 1, 0, '1, 4'd0, 2'd3));
        queue_op(mk_op(MD_ALLOC, '0, 13'd0, 0, 1, 48'h1000, 4'd15, 2'd1));
        queue_op(mk_op(MD_ALLOC, 48'h5555_5555_5555, 13'h1FFF, 0, 1, '0, 4'd0, 2'd2));
        queue_op(mk_op(MD_OVERLAP, 48'hFFFF_FFFF_FFC0, 13'd1, 0, 0, '0, 4'd0, 2'd0));
        queue_op(mk_op(MD_OVERLAP, '0, 13'd0, 0, 0, '0, 4'd0, 2'd0));
        queue_op(mk_op(MD_OVERLAP, 48'h1000, 13'd8, 0, 0, '0, 4'd0, 2'd0));
        queue_op(mk_op(MD_OVERLAP, 48'hAAAA_AAAA_AAAA, 13'h1FFF, 0, 0, '0, 4'd0, 2'd0));
        queue_op(mk_op(MD_MATCH, 48'hFFFF_FFFF_FFC0, 13'd1, 0, 0, '0, 4'd0, 2'd0));
        queue_op(mk_op(MD_TO_FRONT, '0, 13'd1, 0, 0, '0, 4'd1, 2'd0));
        queue_op(mk_op(MD_FRONT, '0, 13'd1, 0, 0, '0, 4'd0, 2'd0));
        queue_op(mk_op(MD_SERVICE, '0, 13'd1, 0, 0, '0, 4'd0, 2'd0));
        queue_op(mk_op(MD_ALLOC_SVC, 48'h1_E240, 13'd1, 0, 0, '0, 4'd0, 2'd3));
        queue_op(mk_op(MD_SERVICE, '0, 13'd1, 0, 0, '0, 4'd0, 2'd0));
        queue_op(mk_op(MD_TO_FRONT, '0, 13'd1, 0, 0, '0, 4'd0, 2'd0));
        queue_op(mk_op(MD_REPEND, '0, 13'd1, 0, 0, '0, 4'd1, 2'd0));
        queue_op(mk_op(MD_REPEND, '0, 13'd1, 0, 0, '0, 4'd0, 2'd0));
        queue_op(mk_op(MD_SERVICE, '0, 13'd1, 0, 0, '0, 4'd1, 2'd0));
        queue_op(mk_op(MD_SQUASH, '0, 13'd1, 0, 0, '0, 4'd0, 2'd1));
        queue_op(mk_op(MD_SQUASH, '0, 13'd1, 0, 0, '0, 4'd0, 2'd3));
        queue_op(mk_op(MD_FREE, '0, 13'd1, 0, 0, '0, 4'd1, 2'd0));
        queue_op(mk_op(4'd12, '0, 13'd1, 0, 0, '0, 4'd0, 2'd0));
        queue_op(mk_op(MD_FREE, '0, 13'd1, 0, 0, '0, 4'd1, 2'd0));
      end else begin
        // the long receiver hold-off fills the block while requests keep coming
        if (ph == 2) hold_req = 1'b1;
        repeat (190) queue_op(rand_op());
      end
      drain();
    end

    $display("%0d operations, %0d results; allocs %0d, searches %0d, entry ops %0d, squashes %0d",
             n_ops, n_results, mode_seen[MD_ALLOC] + mode_seen[MD_ALLOC_SVC],
             mode_seen[MD_MATCH] + mode_seen[MD_OVERLAP] + mode_seen[MD_FRONT],
             mode_seen[MD_SERVICE] + mode_seen[MD_REPEND] + mode_seen[MD_FREE] +
             mode_seen[MD_TO_FRONT], mode_seen[MD_SQUASH]);
    $display("block sizes 8 to 4096 bytes, table limits 1 to 16 entries, %0d mismatches",
             errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/msrf_pkg.sv
hdl/msrf_req_if.sv
hdl/msrf_rsp_if.sv
hdl/miss_status_register_file.sv
tb/tb_miss_status_register_file.sv
